FILE: rtl/button_auto_repeat_duty_control_defines.svh
// Assertion macros for the RTL of the button auto-repeat duty control.
`ifndef BUTTON_AUTO_REPEAT_DUTY_CONTROL_DEFINES_SVH
`define BUTTON_AUTO_REPEAT_DUTY_CONTROL_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define BARDC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Check that cons holds in the cycle after ante.
`define BARDC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/bardc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bardc_pkg;

  localparam int unsigned DUTY_OUT_W = 8;
  localparam int unsigned MS_W       = 8;
  localparam int unsigned CFG_IDX_W  = 2;

  // Button bit positions in the level and pending vectors.
  localparam int unsigned BTN_ONOFF = 0;
  localparam int unsigned BTN_PLUS  = 1;
  localparam int unsigned BTN_MINUS = 2;
  localparam int unsigned BTN_N     = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT   = 2'd2;

  // Register reset values, in ticks.
  localparam logic [MS_W-1:0] DEBOUNCE_RST = 8'd10;
  localparam logic [MS_W-1:0] HOLD_RST     = 8'd20;
  localparam logic [MS_W-1:0] REPEAT_RST   = 8'd5;

  typedef struct packed {
    logic [DUTY_OUT_W-1:0] duty;
    logic                  drive_enabled;
    logic                  busy_res;
  } result_t;

  typedef struct packed {
    logic out_valid;
    logic skid_full;
  } obuf_status_t;

endpackage

`default_nettype wire

FILE: rtl/bardc_obuf.sv
`timescale 1ns / 1ps
`default_nettype none

// Two-deep result buffer: an output register plus a skid register.
module bardc_obuf (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    push_i,
  input  wire bardc_pkg::result_t data_i,
  input  wire                    out_stall_i,
  output bardc_pkg::obuf_status_t status_o,
  output bardc_pkg::result_t     data_o
);
  import bardc_pkg::*;

  logic    main_v_q, main_v_d;
  logic    skid_v_q, skid_v_d;
  result_t main_q, main_d;
  result_t skid_q, skid_d;
  logic    pop;

  assign pop = main_v_q & ~out_stall_i;

  always_comb begin
    main_v_d = main_v_q;
    skid_v_d = skid_v_q;
    main_d   = main_q;
    skid_d   = skid_q;
    if (main_v_q && !pop) begin
      // Output held: park the new word in the skid register.
      if (push_i) begin
        skid_v_d = 1'b1;
        skid_d   = data_i;
      end
    end else if (skid_v_q) begin
      main_v_d = 1'b1;
      main_d   = skid_q;
      skid_v_d = push_i;
      if (push_i) begin
        skid_d = data_i;
      end
    end else begin
      main_v_d = push_i;
      if (push_i) begin
        main_d = data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      main_v_q <= main_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign status_o.out_valid = main_v_q;
  assign status_o.skid_full = skid_v_q;
  assign data_o             = main_q;

endmodule

`default_nettype wire

FILE: rtl/button_auto_repeat_duty_control.sv
// Channel | Direction | Handshake                   | Word
// --------+-----------+-----------------------------+------------------------------------
// in      | input     | in_valid_i / in_stall_o     | onoff_n_i, plus_n_i, minus_n_i
// out     | output    | out_valid_o / out_stall_i   | duty_o, drive_enabled_o, busy_res_o
// cfg     | input     | cfg_valid_i / cfg_ready_o   | cfg_index_i, cfg_data_i
//
// One tick word is taken per clock while not stalled; its result word goes to the output buffer.
// The whole tick update is one pass of logic from the state registers to the result register.
// A two-deep output buffer lets the block take a word while a result waits; in_stall_o rises
// only once both buffer entries are full.
// Reset (rst_ni low, asynchronous) loads the register defaults 10/20/5, duty at mid-scale,
// drive enabled, all buttons released and nothing pending.
// Configuration writes are always ready and take effect for waits started afterwards.
`timescale 1ns / 1ps
`default_nettype none
`include "button_auto_repeat_duty_control_defines.svh"

module button_auto_repeat_duty_control #(
  parameter int unsigned DUTY_BITS = 8
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   in_valid_i,
  output logic                                  in_stall_o,
  input  wire                                   onoff_n_i,
  input  wire                                   plus_n_i,
  input  wire                                   minus_n_i,
  output logic                                  out_valid_o,
  input  wire                                   out_stall_i,
  output logic [bardc_pkg::DUTY_OUT_W-1:0]      duty_o,
  output logic                                  drive_enabled_o,
  output logic                                  busy_res_o,
  input  wire                                   cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire  [bardc_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire  [bardc_pkg::MS_W-1:0]            cfg_data_i
);
  import bardc_pkg::*;

  localparam logic [DUTY_BITS-1:0] DUTY_MAX  = '1;
  localparam logic [DUTY_BITS-1:0] DUTY_INIT = {1'b1, {(DUTY_BITS-1){1'b0}}};

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_DEBOUNCE,
    PH_PLUS,
    PH_MINUS
  } phase_e;

  // Configuration registers.
  logic [MS_W-1:0] debounce_q, hold_q, repeat_q;

  // Tick state.
  logic [BTN_N-1:0]     prev_q, prev_d;
  logic [BTN_N-1:0]     pend_q, pend_d;
  phase_e               phase_q, phase_d;
  logic [MS_W-1:0]      wait_q, wait_d;
  logic [DUTY_BITS-1:0] duty_q, duty_d;
  logic                 en_q, en_d;

  logic                 in_acc;
  logic [BTN_N-1:0]     levels;
  logic [BTN_N-1:0]     pend_in;
  logic [MS_W-1:0]      wait_dec;
  logic [MS_W-1:0]      hold_ld;
  logic [MS_W-1:0]      rep_ld;
  logic [DUTY_BITS-1:0] duty_up;
  logic [DUTY_BITS-1:0] duty_dn;
  logic                 do_dispatch;
  logic                 do_minus;
  logic [DUTY_BITS+DUTY_OUT_W-1:0] duty_ext;

  result_t      res;
  result_t      out_word;
  obuf_status_t buf_st;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= DEBOUNCE_RST;
      hold_q     <= HOLD_RST;
      repeat_q   <= REPEAT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_DEBOUNCE: debounce_q <= cfg_data_i;
        REG_HOLD:     hold_q     <= cfg_data_i;
        REG_REPEAT:   repeat_q   <= cfg_data_i;
        default:      ; // drop writes to unused indexes
      endcase
    end
  end

  assign in_stall_o = buf_st.skid_full;
  assign in_acc     = in_valid_i & ~in_stall_o;

  assign levels   = {minus_n_i, plus_n_i, onoff_n_i};
  // Latch falling edges before anything else this tick.
  assign pend_in  = pend_q | (prev_q & ~levels);
  assign wait_dec = (wait_q == '0) ? '0 : wait_q - 1'b1;
  // A zero hold or repeat time counts as one tick.
  assign hold_ld  = (hold_q == '0) ? MS_W'(1) : hold_q;
  assign rep_ld   = (repeat_q == '0) ? MS_W'(1) : repeat_q;
  assign duty_up  = (duty_q == DUTY_MAX) ? DUTY_MAX : duty_q + 1'b1;
  assign duty_dn  = (duty_q == '0) ? '0 : duty_q - 1'b1;

  always_comb begin
    prev_d      = levels;
    pend_d      = pend_in;
    phase_d     = phase_q;
    wait_d      = wait_q;
    duty_d      = duty_q;
    en_d        = en_q;
    do_dispatch = 1'b0;
    do_minus    = 1'b0;

    unique case (phase_q)
      PH_IDLE: begin
        if (pend_in != '0) begin
          wait_d = debounce_q;
          if (debounce_q == '0) begin
            do_dispatch = 1'b1;
          end else begin
            phase_d = PH_DEBOUNCE;
          end
        end
      end
      PH_DEBOUNCE: begin
        wait_d = wait_dec;
        if (wait_dec == '0) begin
          do_dispatch = 1'b1;
        end
      end
      PH_PLUS, PH_MINUS: begin
        wait_d = wait_dec;
        if (wait_dec == '0) begin
          if (phase_q == PH_PLUS && !levels[BTN_PLUS]) begin
            // Still held: repeat the step.
            duty_d = duty_up;
            wait_d = rep_ld;
          end else if (phase_q == PH_MINUS && !levels[BTN_MINUS]) begin
            duty_d = duty_dn;
            wait_d = rep_ld;
          end else if (phase_q == PH_PLUS) begin
            // Released: retire plus, then minus may still run this round.
            pend_d[BTN_PLUS] = 1'b0;
            do_minus         = 1'b1;
          end else begin
            pend_d[BTN_MINUS] = 1'b0;
            wait_d            = '0;
            phase_d           = PH_IDLE;
          end
        end
      end
      default: begin
        phase_d = PH_IDLE;
        wait_d  = '0;
      end
    endcase

    // Handle pending presses in order: on/off, plus, minus.
    if (do_dispatch) begin
      if (pend_d[BTN_ONOFF]) begin
        en_d              = ~en_q;
        pend_d[BTN_ONOFF] = 1'b0;
      end
      if (pend_d[BTN_PLUS]) begin
        duty_d  = duty_up;
        wait_d  = hold_ld;
        phase_d = PH_PLUS;
      end else begin
        do_minus = 1'b1;
      end
    end

    if (do_minus) begin
      if (pend_d[BTN_MINUS]) begin
        duty_d  = duty_dn;
        wait_d  = hold_ld;
        phase_d = PH_MINUS;
      end else begin
        wait_d  = '0;
        phase_d = PH_IDLE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= '1;
      pend_q  <= '0;
      phase_q <= PH_IDLE;
      wait_q  <= '0;
      duty_q  <= DUTY_INIT;
      en_q    <= 1'b1;
    end else if (in_acc) begin
      prev_q  <= prev_d;
      pend_q  <= pend_d;
      phase_q <= phase_d;
      wait_q  <= wait_d;
      duty_q  <= duty_d;
      en_q    <= en_d;
    end
  end

  // Report the low eight bits of the duty level, zero-filled for narrow levels.
  assign duty_ext          = {{DUTY_OUT_W{1'b0}}, duty_d};
  assign res.duty          = duty_ext[DUTY_OUT_W-1:0];
  assign res.drive_enabled = en_d;
  assign res.busy_res      = (phase_d != PH_IDLE);

  bardc_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_acc),
    .data_i      (res),
    .out_stall_i (out_stall_i),
    .status_o    (buf_st),
    .data_o      (out_word)
  );

  assign out_valid_o     = buf_st.out_valid;
  assign duty_o          = out_word.duty;
  assign drive_enabled_o = out_word.drive_enabled;
  assign busy_res_o      = out_word.busy_res;

  `BARDC_ASSERT_IMPL(a_stall_needs_out, clk_i, rst_ni, in_stall_o, out_valid_o)
  `BARDC_ASSERT_IMPL(a_idle_wait_zero, clk_i, rst_ni, phase_q == PH_IDLE, wait_q == '0)
  `BARDC_ASSERT_IMPL(a_button_wait_live, clk_i, rst_ni,
                     phase_q == PH_PLUS || phase_q == PH_MINUS, wait_q != '0)
  `BARDC_ASSERT_NEXT(a_duty_holds_idle, clk_i, rst_ni, !in_acc, $stable(duty_q))

endmodule

`default_nettype wire
